FILE: hw/rtl/triple_crc16_odd_even_core_assert.svh
// assertion macros shared by the triple crc16 core
`ifndef TRIPLE_CRC16_ODD_EVEN_CORE_ASSERT_SVH
`define TRIPLE_CRC16_ODD_EVEN_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TC16_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TC16_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/tc16_pkg.sv
// types, nibble tables and crc update function for the triple crc16 core
package tc16_pkg;

    // one input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } byte_word_t;

    // one result word
    typedef struct packed {
        logic [15:0] crc_all;
        logic [15:0] crc_odd;
        logic [15:0] crc_even;
    } crc_word_t;

    // contents of the input register
    typedef struct packed {
        logic       valid;
        byte_word_t word;
    } in_hold_t;

    // per-cycle pipeline control
    typedef struct packed {
        logic take;   // held word is consumed by the crc unit this cycle
        logic load;   // result register captures a new result this cycle
    } step_ctrl_t;

    localparam logic [15:0] NIB_HIGH [16] = '{
        16'h0000, 16'hCC01, 16'hD801, 16'h1400, 16'hF001, 16'h3C00, 16'h2800, 16'hE401,
        16'hA001, 16'h6C00, 16'h7800, 16'hB401, 16'h5000, 16'h9C01, 16'h8801, 16'h4400
    };

    localparam logic [15:0] NIB_LOW [16] = '{
        16'h0000, 16'hC0C1, 16'hC181, 16'h0140, 16'hC301, 16'h03C0, 16'h0280, 16'hC241,
        16'hC601, 16'h06C0, 16'h0780, 16'hC741, 16'h0500, 16'hC5C1, 16'hC481, 16'h0440
    };

    // reflected crc16 (poly 0xA001) byte step using two nibble tables
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] x;
        x = crc ^ {8'h00, b};
        return {8'h00, x[15:8]} ^ NIB_LOW[x[3:0]] ^ NIB_HIGH[x[7:4]];
    endfunction

endpackage

FILE: hw/rtl/tc16_in_stage.sv
// input register holding one byte word ahead of the crc unit
module tc16_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_ready,
    input  tc16_pkg::byte_word_t byte_data,
    input  tc16_pkg::step_ctrl_t ctrl,
    output tc16_pkg::in_hold_t   held
);
    import tc16_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    byte_word_t word_reg;

    // room when empty or when the held word leaves this cycle
    assign byte_ready = !valid_reg || ctrl.take;
    assign valid_next = byte_valid || (valid_reg && !ctrl.take);

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            word_reg <= byte_data;
        end
    end

    assign held.valid = valid_reg;
    assign held.word  = word_reg;

endmodule

FILE: hw/rtl/tc16_crc_unit.sv
// running crc state for all, odd and even bytes with one-byte update
module tc16_crc_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tc16_pkg::in_hold_t   held,
    input  tc16_pkg::step_ctrl_t ctrl,
    output tc16_pkg::crc_word_t  result
);
    import tc16_pkg::*;

    logic [15:0] sum_all_reg;
    logic [15:0] sum_odd_reg;
    logic [15:0] sum_even_reg;
    logic        parity_reg;
    logic [15:0] sum_all_next;
    logic [15:0] sum_odd_next;
    logic [15:0] sum_even_next;
    logic        parity_next;
    logic [15:0] base_all;
    logic [15:0] base_odd;
    logic [15:0] base_even;
    logic        base_parity;

    // start flag clears state before the byte is added
    always_comb
    begin
        if (held.word.first_byte)
        begin
            base_all    = 16'h0000;
            base_odd    = 16'h0000;
            base_even   = 16'h0000;
            base_parity = 1'b0;
        end
        else
        begin
            base_all    = sum_all_reg;
            base_odd    = sum_odd_reg;
            base_even   = sum_even_reg;
            base_parity = parity_reg;
        end
    end

    // byte update, odd/even steered by parity
    always_comb
    begin
        sum_all_next  = crc_update(base_all, held.word.data_byte);
        sum_odd_next  = base_odd;
        sum_even_next = base_even;
        if (!base_parity)
        begin
            sum_odd_next = crc_update(base_odd, held.word.data_byte);
        end
        else
        begin
            sum_even_next = crc_update(base_even, held.word.data_byte);
        end
        parity_next = !base_parity;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_all_reg  <= 16'h0000;
            sum_odd_reg  <= 16'h0000;
            sum_even_reg <= 16'h0000;
            parity_reg   <= 1'b0;
        end
        else if (ctrl.take)
        begin
            sum_all_reg  <= sum_all_next;
            sum_odd_reg  <= sum_odd_next;
            sum_even_reg <= sum_even_next;
            parity_reg   <= parity_next;
        end
    end

    assign result.crc_all  = sum_all_next;
    assign result.crc_odd  = sum_odd_next;
    assign result.crc_even = sum_even_next;

endmodule

FILE: hw/rtl/tc16_out_stage.sv
// result register driving the crc output channel
module tc16_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tc16_pkg::step_ctrl_t ctrl,
    input  tc16_pkg::crc_word_t  result,
    output logic                 room,
    output logic                 crc_valid,
    input  logic                 crc_ready,
    output tc16_pkg::crc_word_t  crc_data
);
    import tc16_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    crc_word_t word_reg;

    // free when empty or being drained this cycle
    assign room       = !valid_reg || crc_ready;
    assign valid_next = ctrl.load || (valid_reg && !crc_ready);

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            word_reg <= result;
        end
    end

    assign crc_valid = valid_reg;
    assign crc_data  = word_reg;

endmodule

FILE: hw/rtl/triple_crc16_odd_even_core.sv
// top level of the triple crc16 (all, odd, even bytes) checker
// Usage:
//   byte channel (byte_valid/byte_ready/byte_data) takes one word per cycle while byte_ready is high:
//   a data byte plus first and last flags. first clears all three crcs and
//   the odd/even parity before its byte is added; last makes a result.
//   crc channel (crc_valid/crc_ready/crc_data) gives crc_all, crc_odd and
//   crc_even after each word marked last; other words give no result.
// Timing:
//   one word per cycle while no last word waits for the busy output register;
//   a word sits in the input register while the table-driven byte update runs,
//   and a result is registered in the output register that drives crc_valid.
// Reset:
//   rst_n clears both valid flags, the three crcs and the parity; words
//   without a preceding first flag continue from zero.
// Stall:
//   a result waits in the output register until taken; words not marked
//   last keep flowing meanwhile, and a last word holds in the input register
//   (dropping byte_ready) only while the previous result is still waiting.
module triple_crc16_odd_even_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_ready,
    input  tc16_pkg::byte_word_t byte_data,
    output logic                 crc_valid,
    input  logic                 crc_ready,
    output tc16_pkg::crc_word_t  crc_data
);
    import tc16_pkg::*;

    in_hold_t   held;
    step_ctrl_t ctrl;
    crc_word_t  result;
    logic       room;

    // advance the held word unless it needs the busy result register
    assign ctrl.take = held.valid && (!held.word.last_byte || room);
    assign ctrl.load = ctrl.take && held.word.last_byte;

    tc16_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .ctrl       (ctrl),
        .held       (held)
    );

    tc16_crc_unit u_crc_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .held   (held),
        .ctrl   (ctrl),
        .result (result)
    );

    tc16_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .result    (result),
        .room      (room),
        .crc_valid (crc_valid),
        .crc_ready (crc_ready),
        .crc_data  (crc_data)
    );

    // checks
`include "triple_crc16_odd_even_core_assert.svh"

    `TC16_ASSERT_NOW(a_load_only_last, ctrl.load, held.valid && held.word.last_byte, "result loaded from a word not marked last")
    `TC16_ASSERT_NEXT(a_held_word_kept, held.valid && !ctrl.take, held.valid && $stable(held.word), "held word changed before it was consumed")
    `TC16_ASSERT_NOW(a_ready_when_out_empty, !crc_valid, byte_ready, "input stalled with an empty result register")

endmodule
